### hw/rtl/itt_pkg.sv
// shared types, codes and constants of the interval timer table
`timescale 1ns / 1ps
`default_nettype none

package itt_pkg;

    localparam int TIMER_SLOTS = 32;
    localparam int SLOT_W      = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int MAX_RESULTS = 32;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    localparam logic [5:0] DEFAULT_SIGNAL = 6'd14;

    // raw notify kinds of a create request
    localparam logic [2:0] KIND_SIGNAL    = 3'd0;
    localparam logic [2:0] KIND_NONE      = 3'd1;
    localparam logic [2:0] KIND_THREAD_ID = 3'd4;

    typedef enum logic [2:0] {
        CMD_CREATE  = 3'd0,
        CMD_SETTIME = 3'd1,
        CMD_DELETE  = 3'd2,
        CMD_FLUSH   = 3'd3,
        CMD_TICK    = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_INVAL = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        NOTE_SIGNAL = 2'd0,
        NOTE_NONE   = 2'd1,
        NOTE_THREAD = 2'd2
    } notify_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_READ,
        S_EVAL,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [31:0] timer_id;
        logic signed [31:0] clock_id;
        logic               has_notify_spec;
        logic [2:0]         notify_kind;
        logic signed [31:0] notify_signal;
        logic signed [31:0] notify_thread;
        logic [31:0]        owner_proc;
        logic [47:0]        arm_value_ms;
        logic [31:0]        repeat_ms;
        logic [47:0]        now_ms;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [30:0] new_id;
        logic [47:0] old_remaining_ms;
        logic [31:0] old_repeat_ms;
        logic        fire_valid;
        logic        fire_to_thread;
        logic [31:0] fire_target;
        logic [5:0]  fire_signal;
        logic        last_result;
    } out_item_t;

    typedef struct packed {
        logic [30:0] id;
        notify_t     notify;
        logic [5:0]  signal;
        logic [30:0] thread;
        logic [31:0] owner;
        logic [47:0] expire;
        logic [31:0] interval;
    } slot_rec_t;

    localparam int REC_W = $bits(slot_rec_t);

    typedef struct packed {
        logic load;
        logic quick;
        logic scan_start;
        logic apply;
        logic step;
        logic finish;
    } ctl_cmd_t;

    typedef struct packed {
        logic quick_cmd;
        logic out_free;
        logic apply_blocked;
        logic scan_done;
        logic last_slot;
    } dp_stat_t;

    function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [47:0] b);
        logic [48:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            sat_add48 = s[48] ? '1 : s[47:0];
        end
    endfunction

endpackage

`default_nettype wire

### hw/rtl/interval_timer_table_unit.sv
// top level of the interval timer table
// Commands come in on in_valid/in_ready/in_data, one transfer per command;
// results leave on out_valid/out_ready/out_data, one transfer per result.
// The block works on one command at a time: in_ready is high only while idle.
// Create, unknown commands and flush of owner zero are answered from the
// start state without a slot scan, once the output register is free.
// Settime, delete, flush and tick scan the slot table through its single
// read port, reading each slot in the read state and evaluating it in the
// eval state; settime and delete stop at the first matching slot.
// A tick gives one transfer per delivery (at most 32), the final one marked
// by last_result, or one quiet result if nothing fires.
// A result sits in the output register until taken; while the receiver
// stalls, a step that pushes a result holds; its slot is not yet updated.
// Reset empties the table and sets the next id to one; slot contents need
// no clearing pass, so in_ready is high as soon as reset is released.
`timescale 1ns / 1ps
`default_nettype none

module interval_timer_table_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  itt_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output itt_pkg::out_item_t out_data
);
    import itt_pkg::*;

    ctl_cmd_t cmd;
    dp_stat_t stat;

    itt_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    itt_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cmd      (cmd),
        .stat     (stat),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

endmodule

`default_nettype wire

### hw/rtl/itt_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module itt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### hw/rtl/itt_ctrl.sv
// command sequencer of the interval timer table
`timescale 1ns / 1ps
`default_nettype none

module itt_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  itt_pkg::dp_stat_t stat,
    output itt_pkg::ctl_cmd_t cmd
);
    import itt_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                if (!stat.quick_cmd)
                begin
                    state_next = S_READ;
                end
                else if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_READ:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (!stat.apply_blocked)
                begin
                    if (stat.scan_done)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (stat.last_slot)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_START:
            begin
                cmd.quick      = stat.quick_cmd && stat.out_free;
                cmd.scan_start = !stat.quick_cmd;
            end
            S_READ:
            begin
                cmd = '0;
            end
            S_EVAL:
            begin
                cmd.apply = !stat.apply_blocked;
                cmd.step  = !stat.apply_blocked && !stat.scan_done && !stat.last_slot;
            end
            S_FINISH:
            begin
                cmd.finish = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // slot data is only evaluated after its read was issued
    a_eval_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EVAL |-> $past(state_reg) == S_READ || $past(state_reg) == S_EVAL)
        else $error("eval without a preceding read");

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == S_IDLE)
        else $error("input ready outside idle");

    a_load_on_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> in_valid && in_ready)
        else $error("load without an input transfer");

endmodule

`default_nettype wire

### hw/rtl/itt_dp.sv
// timer table datapath: slot store, id and owner matching, expiry and result staging
`timescale 1ns / 1ps
`default_nettype none

module itt_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  itt_pkg::in_item_t  in_data,
    input  itt_pkg::ctl_cmd_t  cmd,
    output itt_pkg::dp_stat_t  stat,
    output logic               out_valid,
    input  logic               out_ready,
    output itt_pkg::out_item_t out_data
);
    import itt_pkg::*;

    in_item_t                in_reg;
    logic [TIMER_SLOTS-1:0]  used_reg, used_next;
    logic [30:0]             next_id_reg, next_id_next;
    logic [SLOT_W-1:0]       idx_reg, idx_next;
    logic                    pend_valid_reg, pend_valid_next;
    out_item_t               pend_reg, pend_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    out_valid_reg, out_valid_next;
    out_item_t               out_reg, out_next;

    logic                    ram_we;
    logic [SLOT_W-1:0]       ram_waddr;
    slot_rec_t               ram_wdata;
    slot_rec_t               rec;

    logic is_create, is_settime, is_delete, is_flush, is_tick;
    logic out_free;
    logic c_bad;
    notify_t c_note;
    logic [5:0] c_sig;
    logic [30:0] c_thread;
    logic free_found;
    logic [SLOT_W-1:0] free_idx;
    logic [30:0] id_inc;
    logic id_match, owner_match, hit, fire_ok, to_thread;
    logic [47:0] remain;
    logic push;
    out_item_t push_data;
    out_item_t fire_item;
    slot_rec_t rec_mod;

    itt_ram #(
        .WIDTH(REC_W),
        .DEPTH(TIMER_SLOTS)
    ) u_slots (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(idx_reg),
        .rdata(rec)
    );

    assign is_create  = in_reg.command == CMD_CREATE;
    assign is_settime = in_reg.command == CMD_SETTIME;
    assign is_delete  = in_reg.command == CMD_DELETE;
    assign is_flush   = in_reg.command == CMD_FLUSH;
    assign is_tick    = in_reg.command == CMD_TICK;
    assign out_free   = !out_valid_reg || out_ready;

    // create: notify decode
    always_comb
    begin
        c_bad    = in_reg.clock_id[31];
        c_note   = NOTE_SIGNAL;
        c_sig    = DEFAULT_SIGNAL;
        c_thread = '0;
        if (in_reg.has_notify_spec)
        begin
            if (in_reg.notify_signal[31:6] == '0 && in_reg.notify_signal[5:0] != '0)
            begin
                c_sig = in_reg.notify_signal[5:0];
            end
            if (in_reg.notify_kind == KIND_SIGNAL)
            begin
                c_note = NOTE_SIGNAL;
            end
            else if (in_reg.notify_kind == KIND_NONE)
            begin
                c_note = NOTE_NONE;
            end
            else if (in_reg.notify_kind == KIND_THREAD_ID)
            begin
                c_note = NOTE_THREAD;
                if (!in_reg.notify_thread[31])
                begin
                    c_thread = in_reg.notify_thread[30:0];
                end
            end
            else
            begin
                c_bad = 1'b1;
            end
        end
    end

    // lowest free slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = TIMER_SLOTS - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    assign id_inc = next_id_reg + 31'd1;

    // slot evaluation on the registered read data
    assign id_match    = used_reg[idx_reg] && !in_reg.timer_id[31]
                         && rec.id == in_reg.timer_id[30:0];
    assign owner_match = used_reg[idx_reg] && rec.owner == in_reg.owner_proc;
    assign hit         = used_reg[idx_reg] && rec.expire != '0 && in_reg.now_ms >= rec.expire;
    assign fire_ok     = hit && rec.notify != NOTE_NONE && cnt_reg < CNT_W'(MAX_RESULTS);
    assign to_thread   = rec.notify == NOTE_THREAD && rec.thread != '0;
    assign remain      = (rec.expire != '0 && in_reg.now_ms < rec.expire)
                         ? rec.expire - in_reg.now_ms : '0;

    always_comb
    begin
        fire_item                = '0;
        fire_item.status         = ST_OK;
        fire_item.fire_valid     = 1'b1;
        fire_item.fire_to_thread = to_thread;
        fire_item.fire_target    = to_thread ? {1'b0, rec.thread} : rec.owner;
        fire_item.fire_signal    = rec.signal;
    end

    assign stat.quick_cmd     = !(is_settime || is_delete || is_tick
                                  || (is_flush && in_reg.owner_proc != '0));
    assign stat.out_free      = out_free;
    assign stat.scan_done     = (is_settime || is_delete) && id_match;
    assign stat.apply_blocked = !out_free
                                && (stat.scan_done || (is_tick && fire_ok && pend_valid_reg));
    assign stat.last_slot     = idx_reg == SLOT_W'(TIMER_SLOTS - 1);

    always_comb
    begin
        used_next       = used_reg;
        next_id_next    = next_id_reg;
        idx_next        = idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        cnt_next        = cnt_reg;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg;
        ram_wdata       = rec;
        rec_mod         = rec;
        push            = 1'b0;
        push_data       = '0;
        push_data.last_result = 1'b1;

        if (cmd.quick)
        begin
            push = 1'b1;
            push_data.status = ST_OK;
            if (is_create)
            begin
                if (c_bad)
                begin
                    push_data.status = ST_INVAL;
                end
                else if (!free_found)
                begin
                    push_data.status = ST_FULL;
                end
                else
                begin
                    ram_we             = 1'b1;
                    ram_waddr          = free_idx;
                    ram_wdata.id       = next_id_reg;
                    ram_wdata.notify   = c_note;
                    ram_wdata.signal   = c_sig;
                    ram_wdata.thread   = c_thread;
                    ram_wdata.owner    = in_reg.owner_proc;
                    ram_wdata.expire   = '0;
                    ram_wdata.interval = '0;
                    used_next[free_idx] = 1'b1;
                    push_data.new_id   = next_id_reg;
                    next_id_next       = (id_inc == '0) ? 31'd1 : id_inc;
                end
            end
            else if (!is_flush)
            begin
                push_data.status = ST_INVAL;
            end
        end

        if (cmd.scan_start)
        begin
            idx_next        = '0;
            pend_valid_next = 1'b0;
            cnt_next        = '0;
        end

        if (cmd.apply)
        begin
            if (is_settime && id_match)
            begin
                rec_mod.interval = in_reg.repeat_ms;
                rec_mod.expire   = (in_reg.arm_value_ms == '0) ? '0
                                   : sat_add48(in_reg.now_ms, in_reg.arm_value_ms);
                ram_we    = 1'b1;
                ram_wdata = rec_mod;
                push      = 1'b1;
                push_data.status           = ST_OK;
                push_data.old_remaining_ms = remain;
                push_data.old_repeat_ms    = rec.interval;
            end
            else if (is_delete && id_match)
            begin
                used_next[idx_reg] = 1'b0;
                push               = 1'b1;
                push_data.status   = ST_OK;
            end
            else if (is_flush && owner_match)
            begin
                used_next[idx_reg] = 1'b0;
            end
            else if (is_tick && hit)
            begin
                rec_mod.expire = (rec.interval != '0)
                                 ? sat_add48(in_reg.now_ms, {16'd0, rec.interval}) : '0;
                ram_we    = 1'b1;
                ram_wdata = rec_mod;
                if (fire_ok)
                begin
                    // earlier delivery leaves, this one waits to learn if it is the last
                    if (pend_valid_reg)
                    begin
                        push      = 1'b1;
                        push_data = pend_reg;
                        push_data.last_result = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_next       = fire_item;
                    cnt_next        = cnt_reg + 1'b1;
                end
            end
        end

        if (cmd.step)
        begin
            idx_next = idx_reg + 1'b1;
        end

        if (cmd.finish)
        begin
            push = 1'b1;
            push_data.status = (is_settime || is_delete) ? ST_INVAL : ST_OK;
            if (is_tick && pend_valid_reg)
            begin
                push_data = pend_reg;
                push_data.last_result = 1'b1;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (push)
        begin
            out_valid_next = 1'b1;
            out_next       = push_data;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg       <= '0;
            next_id_reg    <= 31'd1;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            used_reg       <= used_next;
            next_id_reg    <= next_id_next;
            idx_reg        <= idx_next;
            pend_valid_reg <= pend_valid_next;
            cnt_reg        <= cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            in_reg <= in_data;
        end
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> out_free)
        else $error("result pushed over an untaken result");

    a_id_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        next_id_reg != 31'd0)
        else $error("next id is zero");

    a_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_RESULTS))
        else $error("delivery count past limit");

endmodule

`default_nettype wire
